// ----- hw/rtl/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
// Used by b2da_cell and binary_to_decimal_ascii; no dependencies.
`default_nettype none

package b2da_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int BCD_W       = 4;
    localparam int DIGIT_COUNT = 10;
    localparam int CNT_W       = $clog2(WORD_W);
    localparam int REM_W       = $clog2(DIGIT_COUNT + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic MODE_SIGNED   = 1'b0;
    localparam logic MODE_UNSIGNED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/b2da_cell.sv -----
// One BCD digit cell of the double-dabble chain: add-3 and shift in a bit
// during conversion, shift whole digits upward during output. Uses b2da_pkg.
`default_nettype none

module b2da_cell (
    input  wire                           clk,
    input  wire                           rst_n,
    input  b2da_pkg::cell_ctl_t           ctl,
    input  wire                           bit_in,
    input  wire  [b2da_pkg::BCD_W-1:0]    digit_in,
    output logic                          bit_out,
    output logic [b2da_pkg::BCD_W-1:0]    digit
);
    import b2da_pkg::*;

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= BCD_W'(5)) ? BCD_W'(digit_reg + BCD_W'(3)) : digit_reg;
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.shift_bit)
        begin
            digit_next = {adj[BCD_W-2:0], bit_in};
        end
        else if (ctl.shift_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign bit_out = adj[BCD_W-1];
    assign digit   = digit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
// Top level of the 32-bit binary to decimal ASCII converter.
// Uses b2da_pkg and a chain of b2da_cell digit cells.
//
// Input channel s_axis: one word per number, tdata = value (32 bits),
// tuser = mode (0 signed two's complement, 1 unsigned).
// Output channel m_axis: one character per word, tdata = ASCII character,
// tlast high on the final character of the number. No leading zeros; zero
// gives "0"; negative signed values start with '-' (0x80000000 signed gives
// -2147483648).
// One number is handled at a time; s_axis_tready is high only when idle.
// After acceptance the magnitude is shifted bit by bit through ten BCD cells,
// then leading zero digits (0 to 9 of them) are dropped at one per cycle,
// then characters leave at one per cycle while m_axis_tready is high.
// Leading zeros and digits always add up to ten. A stall on m_axis holds
// the current character and the digit chain until it is taken. Reset
// returns the block to idle with no word pending.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tlast
);
    import b2da_pkg::*;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   mag_reg, mag_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                neg_reg, neg_next;
    cell_ctl_t           ctl;

    logic [BCD_W-1:0]    digit_w [DIGIT_COUNT];
    logic                carry_w [DIGIT_COUNT];
    logic [BCD_W-1:0]    top_digit;
    logic                in_neg;

    genvar i;
    generate
        for (i = 0; i < DIGIT_COUNT; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                b2da_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .bit_in   (mag_reg[WORD_W-1]),
                    .digit_in ({BCD_W{1'b0}}),
                    .bit_out  (carry_w[i]),
                    .digit    (digit_w[i])
                );
            end
            else
            begin : g_rest
                b2da_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .bit_in   (carry_w[i-1]),
                    .digit_in (digit_w[i-1]),
                    .bit_out  (carry_w[i]),
                    .digit    (digit_w[i])
                );
            end
        end
    endgenerate

    assign top_digit = digit_w[DIGIT_COUNT-1];
    assign in_neg    = (s_axis_tuser[0] == MODE_SIGNED) && s_axis_tdata[WORD_W-1];

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        ctl             = '0;
        s_axis_tready   = 1'b0;
        m_axis_tvalid   = 1'b0;
        m_axis_tdata    = CHAR_ZERO + CHAR_W'(top_digit);
        m_axis_tlast    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    mag_next   = in_neg ? WORD_W'(~s_axis_tdata + WORD_W'(1)) : s_axis_tdata;
                    neg_next   = in_neg;
                    cnt_next   = '0;
                    ctl.clear  = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctl.shift_bit = 1'b1;
                mag_next      = {mag_reg[WORD_W-2:0], 1'b0};
                cnt_next      = CNT_W'(cnt_reg + CNT_W'(1));
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    rem_next   = REM_W'(DIGIT_COUNT);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (rem_reg > REM_W'(1)))
                begin
                    ctl.shift_digit = 1'b1;
                    rem_next        = REM_W'(rem_reg - REM_W'(1));
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = CHAR_MINUS;
                if (m_axis_tready)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = (rem_reg == REM_W'(1));
                if (m_axis_tready)
                begin
                    ctl.shift_digit = 1'b1;
                    rem_next        = REM_W'(rem_reg - REM_W'(1));
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

endmodule

`default_nettype wire
